@@ design/asc_pkg.sv @@
// Shared types and constants for the assignment solution checker.
// Used by the controller, the datapath and the top level; no dependencies.
package asc_pkg;

    // Sizing of the instance tables
    localparam int MAX_SERVERS = 16;
    localparam int MAX_CLIENTS = 64;
    localparam int WORD_BITS   = 16;

    localparam int SRV_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CLI_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    // wide enough for any index field, MAX_SERVERS and MAX_CLIENTS
    localparam int LIM_W = 9;

    localparam int SRV_DEPTH  = 1 << SRV_W;
    localparam int ASG_DEPTH  = 1 << CLI_W;
    localparam int REQ_DEPTH  = (1 << SRV_W) * (1 << CLI_W);
    localparam int DIST_DEPTH = 1 << (2 * SRV_W);
    localparam int FLOW_DEPTH = 1 << (2 * CLI_W);

    localparam int ASG_BITS  = 16;
    localparam int USED_BITS = 22;
    localparam int COST_BITS = 48;
    localparam int PROD_BITS = 2 * WORD_BITS;

    // Item kinds
    localparam logic [2:0] KIND_CAPACITY    = 3'd0;
    localparam logic [2:0] KIND_REQUIREMENT = 3'd1;
    localparam logic [2:0] KIND_LINEAR      = 3'd2;
    localparam logic [2:0] KIND_DISTANCE    = 3'd3;
    localparam logic [2:0] KIND_FLOW        = 3'd4;
    localparam logic [2:0] KIND_ASSIGN      = 3'd5;
    localparam logic [2:0] KIND_CHECK       = 3'd6;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_INVALID  = 2'd1;
    localparam logic [1:0] STAT_CAPACITY = 2'd2;
    localparam logic [1:0] STAT_MISMATCH = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_SERVERS = 2'd0;
    localparam logic [1:0] CFG_NUM_CLIENTS = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS_A,
        ST_DRAIN_A,
        ST_PASS_B,
        ST_PASS_C,
        ST_DRAIN_C,
        ST_TOTAL,
        ST_COMPARE,
        ST_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic run_a;
        logic run_b;
        logic run_c;
        logic do_total;
        logic do_diff;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic n_zero;
        logic a_last;
        logic b_last;
        logic c_last;
        logic busy;
        logic bad;
        logic out_full;
    } sts_t;

endpackage

@@ design/asc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module asc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/asc_ctrl.sv @@
// Sequencing state machine for the assignment solution checker.
// Depends on asc_pkg for the state, command and status types.
module asc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [2:0]      in_kind,
    output logic            in_ready,
    output asc_pkg::cmd_t   cmd,
    input  asc_pkg::sts_t   sts
);

    asc_pkg::state_t state_reg, state_next;
    logic            accept;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == asc_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            asc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == asc_pkg::KIND_CHECK)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = sts.n_zero ? asc_pkg::ST_TOTAL : asc_pkg::ST_PASS_A;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            asc_pkg::ST_PASS_A:
            begin
                cmd.run_a = 1'b1;
                if (sts.a_last)
                begin
                    state_next = asc_pkg::ST_DRAIN_A;
                end
            end
            asc_pkg::ST_DRAIN_A:
            begin
                if (!sts.busy)
                begin
                    state_next = sts.bad ? asc_pkg::ST_RESULT : asc_pkg::ST_PASS_B;
                end
            end
            asc_pkg::ST_PASS_B:
            begin
                cmd.run_b = 1'b1;
                if (sts.b_last)
                begin
                    state_next = asc_pkg::ST_PASS_C;
                end
            end
            asc_pkg::ST_PASS_C:
            begin
                cmd.run_c = 1'b1;
                if (sts.c_last)
                begin
                    state_next = asc_pkg::ST_DRAIN_C;
                end
            end
            asc_pkg::ST_DRAIN_C:
            begin
                if (!sts.busy)
                begin
                    state_next = asc_pkg::ST_TOTAL;
                end
            end
            asc_pkg::ST_TOTAL:
            begin
                cmd.do_total = 1'b1;
                state_next   = asc_pkg::ST_COMPARE;
            end
            asc_pkg::ST_COMPARE:
            begin
                cmd.do_diff = 1'b1;
                state_next  = asc_pkg::ST_RESULT;
            end
            asc_pkg::ST_RESULT:
            begin
                // hold until the output register is free
                if (!sts.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = asc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asc_pkg::ST_IDLE;
            end
        endcase
    end

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == asc_pkg::ST_IDLE) |-> !sts.busy)
        else $error("pipeline still busy while idle");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.out_full)
        else $error("result loaded over a pending transaction");

endmodule

@@ design/asc_datapath.sv @@
// Tables, walk counters, multiply-accumulate pipeline and result register.
// Depends on asc_pkg and asc_ram.
module asc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  asc_pkg::cmd_t       cmd,
    output asc_pkg::sts_t       sts,
    input  logic [2:0]          in_kind,
    input  logic [5:0]          in_row,
    input  logic [5:0]          in_col,
    input  logic [15:0]         in_value,
    input  logic [47:0]         in_claimed,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [1:0]          out_status,
    output logic [21:0]         out_linear,
    output logic [47:0]         out_quadratic,
    output logic [47:0]         out_total
);

    localparam int SW = asc_pkg::SRV_W;
    localparam int CW = asc_pkg::CLI_W;
    localparam int LW = asc_pkg::LIM_W;
    localparam int WB = asc_pkg::WORD_BITS;
    localparam int UB = asc_pkg::USED_BITS;
    localparam int QB = asc_pkg::COST_BITS;
    localparam int PB = asc_pkg::PROD_BITS;

    // Configuration
    logic [4:0]  num_servers_reg;
    logic [6:0]  num_clients_reg;
    logic [15:0] tolerance_reg;
    logic [LW-1:0] m_lim, n_lim, row_x, col_x;

    // Tables held in flops
    logic [WB-1:0] cap_reg  [asc_pkg::SRV_DEPTH];
    logic [UB-1:0] used_reg [asc_pkg::SRV_DEPTH];

    // Walk counters and pipeline
    logic [CW-1:0] j_reg, k_reg, j_d1_reg;
    logic [SW-1:0] i_reg, s_d2_reg;
    logic a_v1_reg, a_v2_reg, c_v1_reg, c_v2_reg, c_v3_reg;
    logic [WB-1:0] flow_d_reg;
    logic [PB-1:0] prod_reg;
    logic          bad_reg, cap_over_reg;
    logic [UB-1:0] lin_reg;
    logic [QB-1:0] quad_reg, total_reg, diff_reg, claimed_reg;
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [UB-1:0] out_linear_reg;
    logic [QB-1:0] out_quad_reg, out_total_reg;

    // RAM ports
    logic [asc_pkg::ASG_BITS-1:0] asgj_rdata, asgk_rdata;
    logic [WB-1:0] req_rdata, lin_rdata, dist_rdata, flow_rdata;
    logic we_req, we_lin, we_dist, we_flow, we_asg;
    logic [SW+CW-1:0] rc_addr, req_raddr;
    logic [2*SW-1:0]  dist_waddr, dist_raddr;
    logic [2*CW-1:0]  flow_waddr, flow_raddr;

    logic a_last, b_last, k_last, c_last;
    logic [UB:0] used_sum, lin_sum;
    logic [QB:0] quad_sum, total_sum, sub_ct, sub_tc;

    // Clamp the in-use counts to the table sizes
    always_comb
    begin
        m_lim = (LW'(num_servers_reg) > LW'(asc_pkg::MAX_SERVERS)) ?
                LW'(asc_pkg::MAX_SERVERS) : LW'(num_servers_reg);
        n_lim = (LW'(num_clients_reg) > LW'(asc_pkg::MAX_CLIENTS)) ?
                LW'(asc_pkg::MAX_CLIENTS) : LW'(num_clients_reg);
        row_x = LW'(in_row);
        col_x = LW'(in_col);
    end

    // Load decode
    always_comb
    begin
        we_req  = cmd.load && (in_kind == asc_pkg::KIND_REQUIREMENT) &&
                  (row_x < LW'(asc_pkg::MAX_SERVERS)) && (col_x < LW'(asc_pkg::MAX_CLIENTS));
        we_lin  = cmd.load && (in_kind == asc_pkg::KIND_LINEAR) &&
                  (row_x < LW'(asc_pkg::MAX_SERVERS)) && (col_x < LW'(asc_pkg::MAX_CLIENTS));
        we_dist = cmd.load && (in_kind == asc_pkg::KIND_DISTANCE) &&
                  (row_x < LW'(asc_pkg::MAX_SERVERS)) && (col_x < LW'(asc_pkg::MAX_SERVERS));
        we_flow = cmd.load && (in_kind == asc_pkg::KIND_FLOW) &&
                  (row_x < LW'(asc_pkg::MAX_CLIENTS)) && (col_x < LW'(asc_pkg::MAX_CLIENTS));
        we_asg  = cmd.load && (in_kind == asc_pkg::KIND_ASSIGN) &&
                  (col_x < LW'(asc_pkg::MAX_CLIENTS));
        rc_addr    = {row_x[SW-1:0], col_x[CW-1:0]};
        dist_waddr = {row_x[SW-1:0], col_x[SW-1:0]};
        flow_waddr = {row_x[CW-1:0], col_x[CW-1:0]};
        req_raddr  = {asgj_rdata[SW-1:0], j_d1_reg};
        dist_raddr = {asgj_rdata[SW-1:0], asgk_rdata[SW-1:0]};
        flow_raddr = {j_reg, k_reg};
    end

    asc_ram #(.WIDTH(WB), .DEPTH(asc_pkg::REQ_DEPTH)) u_req (
        .clk(clk), .we(we_req), .waddr(rc_addr), .wdata(in_value[WB-1:0]),
        .raddr(req_raddr), .rdata(req_rdata));

    asc_ram #(.WIDTH(WB), .DEPTH(asc_pkg::REQ_DEPTH)) u_lin (
        .clk(clk), .we(we_lin), .waddr(rc_addr), .wdata(in_value[WB-1:0]),
        .raddr(req_raddr), .rdata(lin_rdata));

    asc_ram #(.WIDTH(WB), .DEPTH(asc_pkg::DIST_DEPTH)) u_dist (
        .clk(clk), .we(we_dist), .waddr(dist_waddr), .wdata(in_value[WB-1:0]),
        .raddr(dist_raddr), .rdata(dist_rdata));

    asc_ram #(.WIDTH(WB), .DEPTH(asc_pkg::FLOW_DEPTH)) u_flow (
        .clk(clk), .we(we_flow), .waddr(flow_waddr), .wdata(in_value[WB-1:0]),
        .raddr(flow_raddr), .rdata(flow_rdata));

    // Two copies of the assignment so both client indexes read each cycle
    asc_ram #(.WIDTH(asc_pkg::ASG_BITS), .DEPTH(asc_pkg::ASG_DEPTH)) u_asg_j (
        .clk(clk), .we(we_asg), .waddr(col_x[CW-1:0]), .wdata(in_value),
        .raddr(j_reg), .rdata(asgj_rdata));

    asc_ram #(.WIDTH(asc_pkg::ASG_BITS), .DEPTH(asc_pkg::ASG_DEPTH)) u_asg_k (
        .clk(clk), .we(we_asg), .waddr(col_x[CW-1:0]), .wdata(in_value),
        .raddr(k_reg), .rdata(asgk_rdata));

    // Walk end flags and saturating sums
    always_comb
    begin
        a_last    = (LW'(j_reg) + LW'(1)) == n_lim;
        k_last    = (LW'(k_reg) + LW'(1)) == n_lim;
        c_last    = a_last && k_last;
        b_last    = (LW'(i_reg) + LW'(1)) == m_lim;
        used_sum  = {1'b0, used_reg[s_d2_reg]} + (UB+1)'(req_rdata);
        lin_sum   = {1'b0, lin_reg} + (UB+1)'(lin_rdata);
        quad_sum  = {1'b0, quad_reg} + (QB+1)'(prod_reg);
        total_sum = {1'b0, quad_reg} + (QB+1)'(lin_reg);
        sub_ct    = {1'b0, claimed_reg} - {1'b0, total_reg};
        sub_tc    = {1'b0, total_reg} - {1'b0, claimed_reg};
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_servers_reg <= 5'd16;
            num_clients_reg <= 7'd64;
            tolerance_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                asc_pkg::CFG_NUM_SERVERS: num_servers_reg <= cfg_wdata[4:0];
                asc_pkg::CFG_NUM_CLIENTS: num_clients_reg <= cfg_wdata[6:0];
                asc_pkg::CFG_TOLERANCE:   tolerance_reg   <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // Capacity table
    always_ff @(posedge clk)
    begin
        if (cmd.load && (in_kind == asc_pkg::KIND_CAPACITY) &&
            (row_x < LW'(asc_pkg::MAX_SERVERS)))
        begin
            cap_reg[row_x[SW-1:0]] <= in_value[WB-1:0];
        end
    end

    // Per-server usage: clear at check start, accumulate in the first walk
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            for (int s = 0; s < asc_pkg::SRV_DEPTH; s++)
            begin
                used_reg[s] <= '0;
            end
        end
        else if (a_v2_reg)
        begin
            used_reg[s_d2_reg] <= used_sum[UB] ? {UB{1'b1}} : used_sum[UB-1:0];
        end
    end

    // Walk counters and pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg        <= '0;
            k_reg        <= '0;
            i_reg        <= '0;
            a_v1_reg     <= 1'b0;
            a_v2_reg     <= 1'b0;
            c_v1_reg     <= 1'b0;
            c_v2_reg     <= 1'b0;
            c_v3_reg     <= 1'b0;
            bad_reg      <= 1'b0;
            cap_over_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_v1_reg <= cmd.run_a;
            a_v2_reg <= a_v1_reg;
            c_v1_reg <= cmd.run_c;
            c_v2_reg <= c_v1_reg;
            c_v3_reg <= c_v2_reg;
            if (cmd.clear)
            begin
                j_reg        <= '0;
                k_reg        <= '0;
                i_reg        <= '0;
                bad_reg      <= 1'b0;
                cap_over_reg <= 1'b0;
            end
            else
            begin
                if (cmd.run_a)
                begin
                    j_reg <= a_last ? '0 : j_reg + CW'(1);
                end
                if (cmd.run_b)
                begin
                    i_reg <= b_last ? '0 : i_reg + SW'(1);
                    if (used_reg[i_reg] > UB'(cap_reg[i_reg]))
                    begin
                        cap_over_reg <= 1'b1;
                    end
                end
                if (cmd.run_c)
                begin
                    k_reg <= k_last ? '0 : k_reg + CW'(1);
                    if (k_last)
                    begin
                        j_reg <= c_last ? '0 : j_reg + CW'(1);
                    end
                end
                // flag a client whose server is out of range
                if (a_v1_reg && (asgj_rdata >= asc_pkg::ASG_BITS'(m_lim)))
                begin
                    bad_reg <= 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Accumulators and result payload
    always_ff @(posedge clk)
    begin
        if (a_v1_reg)
        begin
            s_d2_reg <= asgj_rdata[SW-1:0];
        end
        if (cmd.run_a)
        begin
            j_d1_reg <= j_reg;
        end
        if (c_v1_reg)
        begin
            flow_d_reg <= flow_rdata;
        end
        if (c_v2_reg)
        begin
            prod_reg <= dist_rdata * flow_d_reg;
        end
        if (cmd.clear)
        begin
            lin_reg     <= '0;
            quad_reg    <= '0;
            claimed_reg <= in_claimed;
        end
        else
        begin
            if (a_v2_reg)
            begin
                lin_reg <= lin_sum[UB] ? {UB{1'b1}} : lin_sum[UB-1:0];
            end
            if (c_v3_reg)
            begin
                quad_reg <= quad_sum[QB] ? {QB{1'b1}} : quad_sum[QB-1:0];
            end
        end
        if (cmd.do_total)
        begin
            total_reg <= total_sum[QB] ? {QB{1'b1}} : total_sum[QB-1:0];
        end
        if (cmd.do_diff)
        begin
            diff_reg <= sub_ct[QB] ? sub_tc[QB-1:0] : sub_ct[QB-1:0];
        end
        if (cmd.load_out)
        begin
            if (bad_reg)
            begin
                out_status_reg <= asc_pkg::STAT_INVALID;
                out_linear_reg <= '0;
                out_quad_reg   <= '0;
                out_total_reg  <= '0;
            end
            else
            begin
                if (cap_over_reg)
                begin
                    out_status_reg <= asc_pkg::STAT_CAPACITY;
                end
                else if (diff_reg > QB'(tolerance_reg))
                begin
                    out_status_reg <= asc_pkg::STAT_MISMATCH;
                end
                else
                begin
                    out_status_reg <= asc_pkg::STAT_OK;
                end
                out_linear_reg <= lin_reg;
                out_quad_reg   <= quad_reg;
                out_total_reg  <= total_reg;
            end
        end
    end

    // Status to the controller and result outputs
    always_comb
    begin
        sts.n_zero   = (n_lim == '0);
        sts.a_last   = a_last;
        sts.b_last   = b_last;
        sts.c_last   = c_last;
        sts.busy     = a_v1_reg || a_v2_reg || c_v1_reg || c_v2_reg || c_v3_reg;
        sts.bad      = bad_reg;
        sts.out_full = out_valid_reg && !out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_linear    = out_linear_reg;
    assign out_quadratic = out_quad_reg;
    assign out_total     = out_total_reg;

    a_mac_order: assert property (@(posedge clk) disable iff (!rst_n)
        c_v3_reg |-> $past(c_v2_reg))
        else $error("accumulate without a product");

    a_bad_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bad_reg) |-> $past(a_v1_reg))
        else $error("invalid flag raised outside the assignment walk");

endmodule

@@ design/assignment_solution_checker_unit.sv @@
// A check with n clients and m servers walks the n clients, then the m servers, then all
// n*n client pairs through the single multiply-accumulate unit, one pair a cycle,
// before it raises m_tvalid. An invalid assignment skips the server and pair walks,
// and n = 0 skips all three walks.
// Throughput: one load per cycle when idle; one check at a time; input waits until it ends.
// Reset: rst_n clears control flags and presets sizes; tables are undefined until written.
// Top level of the assignment solution checker; depends on asc_pkg, asc_ctrl, asc_datapath.
module assignment_solution_checker_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // row[5:0], col[11:6], value[27:12], claimed_cost[75:28]
    input  logic [2:0]   s_tuser,   // kind[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // status[1:0], linear_cost[23:2],
                                    // quadratic_cost[71:24], total_cost[119:72]
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    asc_pkg::cmd_t cmd;
    asc_pkg::sts_t sts;
    logic [1:0]    status;
    logic [21:0]   linear_cost;
    logic [47:0]   quadratic_cost;
    logic [47:0]   total_cost;

    asc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    asc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_kind       (s_tuser),
        .in_row        (s_tdata[5:0]),
        .in_col        (s_tdata[11:6]),
        .in_value      (s_tdata[27:12]),
        .in_claimed    (s_tdata[75:28]),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_status    (status),
        .out_linear    (linear_cost),
        .out_quadratic (quadratic_cost),
        .out_total     (total_cost)
    );

    // Pack the result transaction
    assign m_tdata = {total_cost, quadratic_cost, linear_cost, status};

endmodule
